// File: hw/rtl/lpc_pkg.sv
// ----------------------------------------------------------------------------
// lpc_pkg
// Types and constants shared by the LRU page cache and its slot cells.
// ----------------------------------------------------------------------------
`default_nettype none

package lpc_pkg;

    // Field widths fixed by the item format
    localparam int PAGE_BITS = 32;
    localparam int WORD_BITS = 32;
    localparam int CAP_BITS  = 5;

    // Command codes
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_ADD    = 1'b1;

    // Input item
    typedef struct packed {
        logic                 command;
        logic [PAGE_BITS-1:0] page_number;
        logic [WORD_BITS-1:0] page_word;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic                 hit;
        logic [WORD_BITS-1:0] data_out;
        logic                 evicted;
        logic [PAGE_BITS-1:0] evicted_page;
        logic                 duplicate_error;
    } t_out_item;

    // Contents of one slot, handed between neighbouring cells
    typedef struct packed {
        logic                 valid;
        logic [PAGE_BITS-1:0] page;
        logic [WORD_BITS-1:0] word;
    } t_slot;

    // Broadcast update control for the cell row
    typedef struct packed {
        logic shift;   // promote or evict: shift down, load at the top slot
        logic append;  // plain add: load the first free slot
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: hw/rtl/lpc_cell.sv
// ----------------------------------------------------------------------------
// lpc_cell
// One slot of the recency row: holds a page and its word, compares against
// the requested page and takes its upper neighbour's contents on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module lpc_cell (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire lpc_pkg::t_cell_ctl         i_ctl,
    input  wire [lpc_pkg::PAGE_BITS-1:0]    i_cmp_page,
    input  wire [lpc_pkg::WORD_BITS-1:0]    i_load_word,
    input  wire lpc_pkg::t_slot             i_next_slot,
    input  wire                             i_prev_valid,
    input  wire                             i_after,
    output lpc_pkg::t_slot                  o_slot,
    output logic                            o_match,
    output logic                            o_after,
    output logic [lpc_pkg::WORD_BITS-1:0]   o_sel_word
);

    logic                          r_valid;
    logic [lpc_pkg::PAGE_BITS-1:0] r_page;
    logic [lpc_pkg::WORD_BITS-1:0] r_word;
    logic                          w_top;
    logic                          w_free_first;

    // Tag compare and the "at or above the start point" chain
    assign o_match      = r_valid && (r_page == i_cmp_page);
    assign o_after      = i_after | o_match;
    assign o_sel_word   = o_match ? r_word : '0;

    // Most recent occupied slot, and first empty slot
    assign w_top        = r_valid && !i_next_slot.valid;
    assign w_free_first = !r_valid && i_prev_valid;

    // Valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.append && w_free_first) begin
            r_valid <= 1'b1;
        end
    end

    // Slot contents
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift && w_top) begin
            r_page <= i_cmp_page;
            r_word <= i_load_word;
        end else if (i_ctl.shift && o_after) begin
            r_page <= i_next_slot.page;
            r_word <= i_next_slot.word;
        end else if (i_ctl.append && w_free_first) begin
            r_page <= i_cmp_page;
            r_word <= i_load_word;
        end
    end

    assign o_slot = {r_valid, r_page, r_word};

endmodule

`default_nettype wire

// File: hw/rtl/lru_page_cache.sv
// ----------------------------------------------------------------------------
// lru_page_cache
// Fully associative page cache with least-recently-used replacement, built
// as a row of slot cells kept in recency order (slot 0 least recent).
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_stall   i_in_data  (t_in_item)
// out       output     o_out_valid / i_out_stall o_out_data (t_out_item)
// cfg       input      i_cfg_we                  i_cfg_data (capacity)
//
// One transfer per cycle: every slot compares the page in parallel and the
// row shifts in the same cycle, so the result of an item is registered as
// the item is taken. The output register limits throughput only when the
// result is stalled: input stall follows output stall while a result waits.
// Reset is synchronous; it clears valid bits and occupancy and sets capacity to 16.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_cache #(
    parameter int SLOTS = 16
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire lpc_pkg::t_in_item             i_in_data,
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output lpc_pkg::t_out_item                 o_out_data,
    input  wire                                i_cfg_we,
    input  wire [lpc_pkg::CAP_BITS-1:0]        i_cfg_data
);

    localparam int OCC_BITS = $clog2(SLOTS + 1);
    localparam int CMP_BITS = (OCC_BITS > lpc_pkg::CAP_BITS) ? OCC_BITS : lpc_pkg::CAP_BITS;

    logic [lpc_pkg::CAP_BITS-1:0]  r_capacity;
    logic [OCC_BITS-1:0]           r_occ;
    logic [OCC_BITS-1:0]           n_occ;
    logic                          r_out_valid;
    logic                          n_out_valid;
    lpc_pkg::t_out_item            r_out;
    lpc_pkg::t_out_item            n_out;

    logic                          w_accept;
    logic                          w_is_add;
    logic                          w_any_match;
    logic                          w_evict;
    logic [CMP_BITS-1:0]           w_eff_cap;
    logic [CMP_BITS-1:0]           w_occ_ext;
    logic [lpc_pkg::WORD_BITS-1:0] w_hit_word;
    logic [lpc_pkg::WORD_BITS-1:0] w_load_word;
    lpc_pkg::t_cell_ctl            w_ctl;

    lpc_pkg::t_slot                w_slot     [SLOTS];
    logic [lpc_pkg::WORD_BITS-1:0] w_sel_word [SLOTS];
    logic [SLOTS-1:0]              w_match;
    logic [SLOTS:0]                w_after;

    // Handshake
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_is_add   = (i_in_data.command == lpc_pkg::CMD_ADD);

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lpc_pkg::CAP_BITS'(16);
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_data;
        end
    end

    // Effective capacity: zero reads as one, saturate at the slot count
    always_comb begin
        w_occ_ext = CMP_BITS'(r_occ);
        if (r_capacity == '0) begin
            w_eff_cap = CMP_BITS'(1);
        end else if (CMP_BITS'(r_capacity) > CMP_BITS'(SLOTS)) begin
            w_eff_cap = CMP_BITS'(SLOTS);
        end else begin
            w_eff_cap = CMP_BITS'(r_capacity);
        end
        w_evict = (w_occ_ext >= w_eff_cap);
    end

    // Hit word: at most one slot matches
    always_comb begin
        w_hit_word = '0;
        for (int i = 0; i < SLOTS; i++) begin
            w_hit_word = w_hit_word | w_sel_word[i];
        end
    end

    assign w_any_match = |w_match;
    assign w_load_word = w_is_add ? i_in_data.page_word : w_hit_word;

    // Row control; an evict shifts from slot 0, a promote from the hit slot
    always_comb begin
        w_ctl.shift  = w_accept && (w_is_add ? (!w_any_match && w_evict) : w_any_match);
        w_ctl.append = w_accept && w_is_add && !w_any_match && !w_evict;
    end
    assign w_after[0] = w_is_add;

    // Cell row
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        lpc_pkg::t_slot w_next;
        logic           w_prev_valid;

        if (g == SLOTS - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_slot[g+1];
        end

        if (g == 0) begin : g_first
            assign w_prev_valid = 1'b1;
        end else begin : g_rest
            assign w_prev_valid = w_slot[g-1].valid;
        end

        lpc_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_cmp_page   (i_in_data.page_number),
            .i_load_word  (w_load_word),
            .i_next_slot  (w_next),
            .i_prev_valid (w_prev_valid),
            .i_after      (w_after[g]),
            .o_slot       (w_slot[g]),
            .o_match      (w_match[g]),
            .o_after      (w_after[g+1]),
            .o_sel_word   (w_sel_word[g])
        );
    end

    // Occupancy and result next values
    always_comb begin
        n_occ       = r_occ;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        if (w_ctl.append) begin
            n_occ = r_occ + OCC_BITS'(1);
        end
        if (w_accept) begin
            n_out_valid           = 1'b1;
            n_out.hit             = !w_is_add && w_any_match;
            n_out.data_out        = w_is_add ? '0 : w_hit_word;
            n_out.evicted         = w_is_add && !w_any_match && w_evict;
            n_out.evicted_page    = (w_is_add && !w_any_match && w_evict) ? w_slot[0].page : '0;
            n_out.duplicate_error = w_is_add && w_any_match;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
